// File: rtl/sfng_pkg.sv
package sfng_pkg;

  localparam logic [63:0] MIX_KIND       = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_LAYER      = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] STATE_FALLBACK = 64'h2545f4914f6cdd1d;
  localparam logic [63:0] STAR_MULT      = 64'd2685821657736338717;
  localparam logic [63:0] BASE_SEED_RST  = 64'd1;

  typedef logic [1:0] cmd_t;
  typedef logic [1:0] fmt_t;

  localparam cmd_t CMD_SEED    = 2'd0;
  localparam cmd_t CMD_PAYLOAD = 2'd1;
  localparam cmd_t CMD_SCALE   = 2'd2;
  localparam cmd_t CMD_NOP     = 2'd3;

  localparam fmt_t FMT_NIBBLE = 2'd0;
  localparam fmt_t FMT_F32    = 2'd1;
  localparam fmt_t FMT_BF16   = 2'd2;

  localparam logic [2:0] BYTES_ONE  = 3'd1;
  localparam logic [2:0] BYTES_TWO  = 3'd2;
  localparam logic [2:0] BYTES_FOUR = 3'd4;

  localparam logic [7:0] SCALE_BASE = 8'd120;
  localparam logic [15:0] ZERO_CODE = 16'h8000;

  // Exponent bias for (v - 32768) / 2^k, with the magnitude's MSB at bit p:
  // 127 - k plus p.
  localparam logic [7:0] F32_BIAS  = 8'd109;
  localparam logic [7:0] BF16_BIAS = 8'd107;

  // First register stage, loaded from the inputs: seed mix partial products.
  typedef struct packed {
    cmd_t        cmd;
    fmt_t        fmt;
    logic [63:0] kind_prod;
    logic [63:0] layer_prod_lo;
    logic [31:0] layer_prod_hi;
  } mix_stage_t;

  // Stage registered together with the state update: low 16 bits of the scrambled output.
  typedef struct packed {
    cmd_t        cmd;
    fmt_t        fmt;
    logic [15:0] rnd;
  } rnd_stage_t;

  // IEEE single pattern of (v - 32768) / 2^k, with bias = 127 - k.
  function automatic logic [31:0] scaled_pattern(input logic [15:0] v,
                                                 input logic [7:0] bias);
    logic        sign;
    logic [15:0] mag;
    logic [3:0]  msb;
    logic [15:0] norm;
    logic [7:0]  expo;
    sign = 1'b0;
    mag  = 16'd0;
    msb  = 4'd0;
    if (v[15]) begin
      mag = {1'b0, v[14:0]};
    end else begin
      sign = 1'b1;
      mag  = ZERO_CODE - v;
    end
    for (int i = 0; i < 16; i++) begin
      if (mag[i]) begin
        msb = 4'(i);
      end
    end
    norm = mag << (4'd15 - msb);
    expo = bias + {4'd0, msb};
    if (v == ZERO_CODE) begin
      scaled_pattern = 32'd0;
    end else begin
      scaled_pattern = {sign, expo, norm[14:0], 8'd0};
    end
  endfunction

endpackage

// File: rtl/seeded_format_noise_generator.sv
// Seeded format noise generator: reproducible test patterns for weight memories.
// Input channel (in_valid / in_stall) takes one command per item: a seed load
// builds the 64-bit generator state from the base seed, the tensor kind and the
// layer index; a payload or scale command steps the xorshift64* generator once
// and yields one element on the output channel (out_valid / out_stall).
// A seed load or the unused command code gives no result.
// The base seed is written on the cfg_valid / cfg_ready port, which is always
// ready; write it only while no item is in flight.
// out_valid rises once an accepted command has passed three registers: the seed
// mix product register, the state register with the scrambled output register,
// and the formatted output register.
// One item is accepted every cycle while in_stall is low; the state register,
// which steps once per item, sets that rate.
// When the receiver stalls, the output holds and the stages behind it keep
// taking items until they are full, then in_stall rises.
// Synchronous reset clears all valid flags, sets the base seed to 1 and the
// generator state to its fallback constant.
module seeded_format_noise_generator
  import sfng_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [1:0]  in_element_format,
  input  logic [7:0]  in_tensor_kind,
  input  logic [31:0] in_layer_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_element_data,
  output logic [2:0]  out_element_bytes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);

  logic [63:0] base_seed_r, base_seed_nxt;
  mix_stage_t  mix_q;
  logic        mix_valid;
  logic        mix_take;
  rnd_stage_t  rnd_q;
  logic        rnd_valid;
  logic        rnd_take;

  assign cfg_ready = 1'b1;

  always_comb begin
    base_seed_nxt = base_seed_r;
    if (cfg_valid && cfg_ready) begin
      base_seed_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_seed_r <= BASE_SEED_RST;
    end else begin
      base_seed_r <= base_seed_nxt;
    end
  end

  sfng_seed_mix u_seed_mix (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_element_format (in_element_format),
    .in_tensor_kind    (in_tensor_kind),
    .in_layer_index    (in_layer_index),
    .mix_q             (mix_q),
    .mix_valid         (mix_valid),
    .mix_take          (mix_take)
  );

  sfng_state_step u_state_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .base_seed (base_seed_r),
    .mix_q     (mix_q),
    .mix_valid (mix_valid),
    .mix_take  (mix_take),
    .rnd_q     (rnd_q),
    .rnd_valid (rnd_valid),
    .rnd_take  (rnd_take)
  );

  sfng_format u_format (
    .clk               (clk),
    .rst_n             (rst_n),
    .rnd_q             (rnd_q),
    .rnd_valid         (rnd_valid),
    .rnd_take          (rnd_take),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_element_data  (out_element_data),
    .out_element_bytes (out_element_bytes)
  );

endmodule

// File: rtl/sfng_seed_mix.sv
module sfng_seed_mix
  import sfng_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [1:0]  in_element_format,
  input  logic [7:0]  in_tensor_kind,
  input  logic [31:0] in_layer_index,
  output mix_stage_t  mix_q,
  output logic        mix_valid,
  input  logic        mix_take
);

  mix_stage_t  mix_r, mix_nxt;
  logic        mix_valid_r, mix_valid_nxt;
  logic        accept;
  logic [8:0]  kind_inc;
  logic [31:0] layer_inc;

  assign in_stall = mix_valid_r && !mix_take;
  assign accept   = in_valid && !in_stall;

  // The 64 x 32 layer product is split into two 32 x 32 halves; only the
  // low word of the upper half survives the 64-bit wrap.
  always_comb begin
    kind_inc  = {1'b0, in_tensor_kind} + 9'd1;
    layer_inc = in_layer_index + 32'd1;
    mix_nxt.cmd           = in_command;
    mix_nxt.fmt           = in_element_format;
    mix_nxt.kind_prod     = 64'(MIX_KIND * {55'd0, kind_inc});
    mix_nxt.layer_prod_lo = {32'd0, MIX_LAYER[31:0]} * {32'd0, layer_inc};
    mix_nxt.layer_prod_hi = 32'(MIX_LAYER[63:32] * layer_inc);
  end

  always_comb begin
    if (accept) begin
      mix_valid_nxt = 1'b1;
    end else if (mix_take) begin
      mix_valid_nxt = 1'b0;
    end else begin
      mix_valid_nxt = mix_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_valid_r <= 1'b0;
    end else begin
      mix_valid_r <= mix_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mix_r <= mix_nxt;
    end
  end

  assign mix_q     = mix_r;
  assign mix_valid = mix_valid_r;

endmodule

// File: rtl/sfng_state_step.sv
module sfng_state_step
  import sfng_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [63:0] base_seed,
  input  mix_stage_t  mix_q,
  input  logic        mix_valid,
  output logic        mix_take,
  output rnd_stage_t  rnd_q,
  output logic        rnd_valid,
  input  logic        rnd_take
);

  logic [63:0] state_r, state_nxt;
  logic        rnd_valid_r, rnd_valid_nxt;
  rnd_stage_t  rnd_r, rnd_nxt;
  logic [63:0] seed_mix;
  logic [63:0] s1, s2, s3;
  logic        has_result;
  logic        rnd_free;

  assign has_result = (mix_q.cmd == CMD_PAYLOAD) || (mix_q.cmd == CMD_SCALE);
  assign rnd_free   = !rnd_valid_r || rnd_take;
  // Items that give no result never wait for the next stage.
  assign mix_take   = mix_valid && (rnd_free || !has_result);

  // The two halves of the layer product are summed, so the carry out of the
  // low half reaches the upper word.
  always_comb begin
    seed_mix = base_seed ^ mix_q.kind_prod
             ^ (mix_q.layer_prod_lo + {mix_q.layer_prod_hi, 32'd0});
    s1 = state_r ^ (state_r >> 12);
    s2 = s1 ^ (s1 << 25);
    s3 = s2 ^ (s2 >> 27);
  end

  always_comb begin
    state_nxt = state_r;
    if (mix_take) begin
      unique case (mix_q.cmd)
        CMD_SEED: begin
          state_nxt = (seed_mix == 64'd0) ? STATE_FALLBACK : seed_mix;
        end
        CMD_PAYLOAD, CMD_SCALE: begin
          state_nxt = s3;
        end
        default: begin
          state_nxt = state_r;
        end
      endcase
    end
  end

  // Only the low 16 bits of the scrambled word are ever used, and those
  // depend only on the low 16 bits of both factors.
  always_comb begin
    rnd_nxt.cmd = mix_q.cmd;
    rnd_nxt.fmt = mix_q.fmt;
    rnd_nxt.rnd = 16'(s3[15:0] * STAR_MULT[15:0]);
  end

  always_comb begin
    if (mix_take && has_result) begin
      rnd_valid_nxt = 1'b1;
    end else if (rnd_take) begin
      rnd_valid_nxt = 1'b0;
    end else begin
      rnd_valid_nxt = rnd_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_FALLBACK;
      rnd_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_valid_r <= rnd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mix_take && has_result) begin
      rnd_r <= rnd_nxt;
    end
  end

  assign rnd_q     = rnd_r;
  assign rnd_valid = rnd_valid_r;

endmodule

// File: rtl/sfng_format.sv
module sfng_format
  import sfng_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  rnd_stage_t  rnd_q,
  input  logic        rnd_valid,
  output logic        rnd_take,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_element_data,
  output logic [2:0]  out_element_bytes
);

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] data_r, data_nxt;
  logic [2:0]  bytes_r, bytes_nxt;
  logic [31:0] f32_word;
  logic [31:0] bf16_word;
  logic        out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign rnd_take = rnd_valid && out_free;

  always_comb begin
    f32_word  = scaled_pattern(rnd_q.rnd, F32_BIAS);
    bf16_word = scaled_pattern(rnd_q.rnd, BF16_BIAS);
    if (rnd_q.cmd == CMD_SCALE) begin
      data_nxt  = {24'd0, SCALE_BASE + {5'd0, rnd_q.rnd[2:0]}};
      bytes_nxt = BYTES_ONE;
    end else begin
      case (rnd_q.fmt)
        FMT_NIBBLE: begin
          data_nxt  = {24'd0, rnd_q.rnd[7:0]};
          bytes_nxt = BYTES_ONE;
        end
        FMT_F32: begin
          data_nxt  = f32_word;
          bytes_nxt = BYTES_FOUR;
        end
        default: begin
          // The reserved format code also takes the bf16 path.
          data_nxt  = {16'd0, bf16_word[31:16]};
          bytes_nxt = BYTES_TWO;
        end
      endcase
    end
  end

  always_comb begin
    if (rnd_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rnd_take) begin
      data_r  <= data_nxt;
      bytes_r <= bytes_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_element_data  = data_r;
  assign out_element_bytes = bytes_r;

endmodule
